FILE: sv/dpi_pkg.sv
package dpi_pkg;
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] ST_ANSWERED = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  localparam int DataW = 24;
  localparam int EntryW = 72;

  // Datapath command: strobes and selects from the controller
  typedef struct packed {
    logic load_item;    // capture the input item
    logic rd_issue;     // issue memory read at rd_addr
    logic rd_capture;   // capture read data into lo (0) or hi (1) slot
    logic rd_slot;
    logic wr_shift;     // write shifted entry (from read data) at wr_addr
    logic wr_new;       // write captured item at wr_addr
    logic div_start;
    logic mul_start;
    logic out_load;     // load output register
    logic [2:0] out_status;
    logic [1:0] out_src; // 0 zero, 1 lo slot, 2 interpolation
  } dpi_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic cmp_le;   // item depth <= read depth
    logic cmp_lt;   // item depth < read depth
    logic out_busy;
  } dpi_sts_t;

  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_LO   = 2'd1;
  localparam logic [1:0] SRC_LERP = 2'd2;
endpackage

FILE: sv/dpi_ram.sv
module dpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/dpi_datapath.sv
module dpi_datapath #(
  parameter int LEVELS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dpi_pkg::dpi_cmd_t         cmd,
  input  logic [$clog2(LEVELS)-1:0] rd_addr,
  input  logic [$clog2(LEVELS)-1:0] wr_addr,
  output dpi_pkg::dpi_sts_t         sts,
  input  logic [71:0]               in_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [50:0]               out_data
);
  logic signed [23:0] q_depth, q_north, q_east;
  logic [71:0] rdata, wdata;
  logic        we;
  logic signed [23:0] lo_d, lo_n, lo_e, hi_d, hi_n, hi_e;
  logic signed [23:0] r_d;

  assign r_d = rdata[23:0];
  assign we = cmd.wr_shift | cmd.wr_new;
  assign wdata = cmd.wr_new ? {q_east, q_north, q_depth} : rdata;

  dpi_ram #(.WIDTH(dpi_pkg::EntryW), .DEPTH(LEVELS)) u_ram (
    .clk(clk), .we(we), .waddr(wr_addr), .wdata(wdata),
    .raddr(rd_addr), .rdata(rdata)
  );

  assign sts.cmp_le = q_depth <= r_d;
  assign sts.cmp_lt = q_depth < r_d;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      q_depth <= in_data[23:0];
      q_north <= in_data[47:24];
      q_east  <= in_data[71:48];
    end
    if (cmd.rd_capture && !cmd.rd_slot) begin
      lo_d <= rdata[23:0]; lo_n <= rdata[47:24]; lo_e <= rdata[71:48];
    end
    if (cmd.rd_capture && cmd.rd_slot) begin
      hi_d <= rdata[23:0]; hi_n <= rdata[47:24]; hi_e <= rdata[71:48];
    end
  end

  // Restoring divider: w = (diff<<16)/span, 17 quotient bits, one per cycle.
  // diff <= span, so diff>>1 < span and the upper quotient bits are zero:
  // preload the remainder with diff>>1 and shift in diff[0] then 16 zeros.
  logic [24:0] span, rem, diff;
  logic [16:0] num;
  logic [16:0] quo;
  logic [4:0]  dcnt;
  logic        dbusy;
  logic        ddone;
  logic [25:0] trial;

  assign diff  = 25'({q_depth[23], q_depth} - {lo_d[23], lo_d});
  assign trial = {rem, num[16]} - {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
      ddone <= 1'b0;
    end else begin
      ddone <= dbusy && (dcnt == 5'd16);
      if (cmd.div_start) begin
        dbusy <= 1'b1;
        dcnt  <= 5'd0;
      end else if (dbusy) begin
        if (dcnt == 5'd16) dbusy <= 1'b0;
        dcnt <= dcnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      span <= 25'({hi_d[23], hi_d} - {lo_d[23], lo_d});
      num  <= {diff[0], 16'd0};
      rem  <= {1'b0, diff[24:1]};
      quo  <= '0;
    end else if (dbusy) begin
      num <= {num[15:0], 1'b0};
      if (!trial[25]) begin
        rem <= trial[24:0];
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= {rem[23:0], num[16]};
        quo <= {quo[15:0], 1'b0};
      end
    end
  end

  assign sts.div_done = ddone;

  // Multiply: two registered products, then add
  logic signed [42:0] pn, pe;
  logic               mstage;

  always_ff @(posedge clk) begin
    if (rst) mstage <= 1'b0;
    else     mstage <= cmd.mul_start;
    if (cmd.mul_start) begin
      pn <= $signed({1'b0, quo}) * ($signed({hi_n[23], hi_n}) - $signed({lo_n[23], lo_n}));
      pe <= $signed({1'b0, quo}) * ($signed({hi_e[23], hi_e}) - $signed({lo_e[23], lo_e}));
    end
  end
  assign sts.mul_done = mstage;

  logic signed [23:0] rn, re;
  assign rn = 24'(lo_n + 24'(pn >>> 16));
  assign re = 24'(lo_e + 24'(pe >>> 16));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      unique case (cmd.out_src)
        dpi_pkg::SRC_LO:   out_data <= {cmd.out_status, lo_e, lo_n};
        dpi_pkg::SRC_LERP: out_data <= {cmd.out_status, re, rn};
        default:           out_data <= {cmd.out_status, 48'd0};
      endcase
    end
  end
  assign sts.out_busy = out_valid && !out_ready;
endmodule

FILE: sv/dpi_ctrl.sv
module dpi_ctrl #(
  parameter int LEVELS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_mode,
  output dpi_pkg::dpi_cmd_t         cmd,
  output logic [$clog2(LEVELS)-1:0] rd_addr,
  output logic [$clog2(LEVELS)-1:0] wr_addr,
  input  dpi_pkg::dpi_sts_t         sts,
  output logic [$clog2(LEVELS):0]   count_o
);
  localparam int AW = $clog2(LEVELS);
  localparam logic [3:0] S_IDLE = 4'd0, S_DISPATCH = 4'd1, S_RDF = 4'd2,
    S_CHKF = 4'd3, S_RDL = 4'd4, S_CHKL = 4'd5, S_SRCH = 4'd6,
    S_SRCHW = 4'd7, S_RDLO = 4'd8, S_RDLOW = 4'd9, S_DIV = 4'd10,
    S_MUL = 4'd11, S_OUT = 4'd12, S_SHRD = 4'd13, S_SHWR = 4'd14;

  logic [3:0]  state, state_next;
  logic [1:0]  mode;
  logic [AW:0] count, count_next;
  logic [AW:0] lb, ub, mid;   // binary search window [lb, ub)
  logic [AW+1:0] mid_sum;
  logic [AW:0] lb_next, ub_next;
  logic [AW:0] ptr, ptr_next;
  logic [2:0]  ost, ost_next;
  logic [1:0]  osrc, osrc_next;
  logic [1:0]  mode_next;

  assign mid_sum = {1'b0, lb} + {1'b0, ub};
  assign mid = mid_sum[AW+1:1];
  assign count_o = count;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    mode <= mode_next; lb <= lb_next; ub <= ub_next; ptr <= ptr_next;
    ost <= ost_next; osrc <= osrc_next;
  end

  always_comb begin
    state_next = state; count_next = count; mode_next = mode;
    lb_next = lb; ub_next = ub; ptr_next = ptr; ost_next = ost; osrc_next = osrc;
    cmd = '0;
    rd_addr = AW'(mid);
    wr_addr = AW'(ptr);
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_mode != dpi_pkg::MODE_UNUSED) begin
          cmd.load_item = 1'b1;
          mode_next = in_mode;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (mode == dpi_pkg::MODE_CLEAR) begin
          count_next = '0;
          ost_next = dpi_pkg::ST_CLEARED; osrc_next = dpi_pkg::SRC_ZERO;
          state_next = S_OUT;
        end else if (mode == dpi_pkg::MODE_LOAD) begin
          if (count == (AW+1)'(LEVELS)) begin
            ost_next = dpi_pkg::ST_FULL; osrc_next = dpi_pkg::SRC_ZERO;
            state_next = S_OUT;
          end else begin
            // search first entry with depth > item (upper bound)
            lb_next = '0; ub_next = count;
            state_next = S_SRCH;
          end
        end else begin
          if (count == '0) begin
            ost_next = dpi_pkg::ST_EMPTY; osrc_next = dpi_pkg::SRC_ZERO;
            state_next = S_OUT;
          end else begin
            rd_addr = '0;
            cmd.rd_issue = 1'b1;
            state_next = S_RDF;
          end
        end
      end
      S_RDF: begin
        rd_addr = '0;
        cmd.rd_capture = 1'b1; cmd.rd_slot = 1'b0;
        if (sts.cmp_le) begin
          ost_next = dpi_pkg::ST_ANSWERED; osrc_next = dpi_pkg::SRC_LO;
          state_next = S_OUT;
        end else begin
          state_next = S_CHKF;
        end
      end
      S_CHKF: begin
        rd_addr = AW'(count - 1'b1);
        state_next = S_RDL;
      end
      S_RDL: begin
        rd_addr = AW'(count - 1'b1);
        state_next = S_CHKL;
      end
      S_CHKL: begin
        rd_addr = AW'(count - 1'b1);
        if (!sts.cmp_lt) begin
          cmd.rd_capture = 1'b1; cmd.rd_slot = 1'b0;
          ost_next = dpi_pkg::ST_ANSWERED; osrc_next = dpi_pkg::SRC_LO;
          state_next = S_OUT;
        end else begin
          // lower bound search over [1, last): first depth >= item
          lb_next = (AW+1)'(1); ub_next = count - 1'b1;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lb == ub) begin
          ptr_next = lb;
          if (mode == dpi_pkg::MODE_LOAD) begin
            ptr_next = count;
            state_next = S_SHRD;
          end else begin
            rd_addr = AW'(lb);
            state_next = S_RDLO;
          end
        end else begin
          state_next = S_SRCHW;
        end
      end
      S_SRCHW: begin
        // read data for mid is valid now
        if (mode == dpi_pkg::MODE_LOAD ? sts.cmp_lt : sts.cmp_le) ub_next = mid;
        else lb_next = mid + 1'b1;
        state_next = S_SRCH;
      end
      S_RDLO: begin
        rd_addr = AW'(ptr);
        cmd.rd_capture = 1'b1; cmd.rd_slot = 1'b1;
        ptr_next = ptr - 1'b1;
        state_next = S_RDLOW;
      end
      S_RDLOW: begin
        // lb steps past ub as a phase count: wait for the lo read, capture, divide
        rd_addr = AW'(ptr);
        if (lb == ub + (AW+1)'(2)) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else if (lb == ub + 1'b1) begin
          cmd.rd_capture = 1'b1; cmd.rd_slot = 1'b0;
          lb_next = ub + (AW+1)'(2);
        end else begin
          lb_next = ub + 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.mul_start = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          ost_next = dpi_pkg::ST_ANSWERED; osrc_next = dpi_pkg::SRC_LERP;
          state_next = S_OUT;
        end
      end
      S_SHRD: begin
        // shift entries up from count-1 down to lb
        if (ptr == lb) begin
          cmd.wr_new = 1'b1;
          wr_addr = AW'(lb);
          count_next = count + 1'b1;
          ost_next = dpi_pkg::ST_STORED; osrc_next = dpi_pkg::SRC_ZERO;
          state_next = S_OUT;
        end else begin
          rd_addr = AW'(ptr - 1'b1);
          state_next = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        wr_addr = AW'(ptr);
        ptr_next = ptr - 1'b1;
        state_next = S_SHRD;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_status = ost;
          cmd.out_src = osrc;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: sv/depth_profile_interpolator_top.sv
// Clear, full and empty answers are loaded straight into the result; a query at or above the
// first level or at or below the last level is answered from that entry; an interpolated query
// runs a binary search, the 17-step divider and a multiply. A load runs a binary search, then
// moves each level from the insertion point on up one slot.
// Throughput: one item at a time; the next transfer is taken once the result is loaded.
// Reset: synchronous, active high; empties the table and drops any pending result.
module depth_profile_interpolator_top #(
  parameter int LEVELS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // mode
  input  logic [71:0] s_tdata,   // depth[23:0], north_speed[47:24], east_speed[71:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // status
  output logic [47:0] m_tdata    // north_current[23:0], east_current[47:24]
);
  localparam int AW = $clog2(LEVELS);

  dpi_pkg::dpi_cmd_t cmd;
  dpi_pkg::dpi_sts_t sts;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [AW:0]   count;
  logic [50:0]   out_data;

  // Controller: sequences search, shift, divide and result transfer
  dpi_ctrl #(.LEVELS(LEVELS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_mode(s_tuser), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr),
    .sts(sts), .count_o(count)
  );

  // Datapath: level memory, divider, multipliers and output register
  dpi_datapath #(.LEVELS(LEVELS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr),
    .sts(sts), .in_data(s_tdata), .out_ready(m_tready), .out_valid(m_tvalid),
    .out_data(out_data)
  );

  assign m_tdata = out_data[47:0];
  assign m_tuser = out_data[50:48];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(LEVELS)) else $error("level count overflow");
  a_zero_cur: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != dpi_pkg::ST_ANSWERED |-> m_tdata == '0)
    else $error("currents nonzero on non-answer");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.div_start) else $error("divider started while idle");
`endif
endmodule

FILE: tb/sv/depth_profile_interpolator_top_test.sv
module depth_profile_interpolator_top_test;
  localparam int LEVELS = 64;

  // One input item: mode travels as tuser, the rest packed into tdata.
  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] east;
    logic [23:0] north;
    logic [23:0] depth;
  } level_item_t;

  // One answer: status travels as tuser, the currents packed into tdata.
  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] east;
    logic [23:0] north;
  } current_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;   // mode
  logic [71:0] s_tdata = '0;   // depth[23:0], north_speed[47:24], east_speed[71:48]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [2:0]  m_tuser;        // status
  logic [47:0] m_tdata;        // north_current[23:0], east_current[47:24]

  depth_profile_interpolator_top #(.LEVELS(LEVELS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Predictor's own copy of the table.
  logic signed [23:0] prof_depth [LEVELS];
  logic signed [23:0] prof_north [LEVELS];
  logic signed [23:0] prof_east  [LEVELS];
  int prof_count;

  level_item_t     pending_items [$];
  current_answer_t expected_answers [$];
  int  mismatch_count;
  int  answers_seen;
  int  queries_lerp;
  bit  hold_sender;
  bit  pressure_done;

  function automatic logic signed [23:0] blend(logic signed [23:0] lo, logic signed [23:0] hi,
                                               longint w);
    longint prod;
    prod = w * (longint'(hi) - longint'(lo));
    return 24'(longint'(lo) + (prod >>> 16));
  endfunction

  // Apply one item to the predicted table and return the answer it causes.
  function automatic current_answer_t predict_answer(level_item_t it);
    current_answer_t a;
    logic signed [23:0] d;
    int pos, hi, lo, last;
    longint span, w;
    a = '0;
    d = it.depth;
    case (it.mode)
      dpi_pkg::MODE_LOAD: begin
        if (prof_count >= LEVELS) begin
          a.status = dpi_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < prof_count && prof_depth[pos] <= d) pos++;
          for (int i = prof_count; i > pos; i--) begin
            prof_depth[i] = prof_depth[i-1];
            prof_north[i] = prof_north[i-1];
            prof_east[i]  = prof_east[i-1];
          end
          prof_depth[pos] = d;
          prof_north[pos] = it.north;
          prof_east[pos]  = it.east;
          prof_count++;
          a.status = dpi_pkg::ST_STORED;
        end
      end
      dpi_pkg::MODE_QUERY: begin
        if (prof_count == 0) begin
          a.status = dpi_pkg::ST_EMPTY;
        end else begin
          last = prof_count - 1;
          a.status = dpi_pkg::ST_ANSWERED;
          if (d <= prof_depth[0]) begin
            a.north = prof_north[0];
            a.east  = prof_east[0];
          end else if (d >= prof_depth[last]) begin
            a.north = prof_north[last];
            a.east  = prof_east[last];
          end else begin
            hi = 1;
            while (hi < last && prof_depth[hi] < d) hi++;
            lo = hi - 1;
            span = longint'(prof_depth[hi]) - longint'(prof_depth[lo]);
            w = 0;
            if (span > 0) w = ((longint'(d) - longint'(prof_depth[lo])) <<< 16) / span;
            a.north = blend(prof_north[lo], prof_north[hi], w);
            a.east  = blend(prof_east[lo], prof_east[hi], w);
            queries_lerp++;
          end
        end
      end
      dpi_pkg::MODE_CLEAR: begin
        prof_count = 0;
        a.status = dpi_pkg::ST_CLEARED;
      end
      default: a.status = '1;  // unused mode: no answer
    endcase
    return a;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [23:0] rand_depth(int style);
    case (style)
      0: return 24'($urandom_range(0, 40) * 256);   // coarse grid, many repeats
      1: return 24'($urandom());
      default: return 24'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic push_item(logic [1:0] mode, logic [23:0] depth, logic [23:0] north,
                           logic [23:0] east);
    level_item_t it;
    it.mode = mode; it.depth = depth; it.north = north; it.east = east;
    pending_items = {pending_items, it};
  endtask

  // Driver: take items from the queue, predict each at its transfer.
  int drv_gap = 0;
  always @(posedge clk) begin
    current_answer_t a;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        a = predict_answer(level_item_t'({s_tuser, s_tdata}));
        if (s_tuser != dpi_pkg::MODE_UNUSED) expected_answers = {expected_answers, a};
      end
      if (!s_tvalid || s_tready) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0 && !hold_sender) begin
          {s_tuser, s_tdata} <= pending_items.pop_front();
          s_tvalid <= 1'b1;
          drv_gap <= gap_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each answer with the oldest expectation, stall at random.
  always @(posedge clk) begin
    current_answer_t exp_a, got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        answers_seen++;
        if (expected_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected answer %h", got);
        end else begin
          exp_a = expected_answers.pop_front();
          if (got.status !== exp_a.status || got.north !== exp_a.north ||
              got.east !== exp_a.east) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected st=%0d n=%h e=%h, actual st=%0d n=%h e=%h",
                       exp_a.status, exp_a.north, exp_a.east, got.status, got.north, got.east);
          end
        end
      end
      m_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int n, style;
    logic [1:0] md;
    mismatch_count = 0; answers_seen = 0; queries_lerp = 0;
    hold_sender = 0; pressure_done = 0; prof_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty query, extremes, duplicates, unused mode, clear.
    push_item(dpi_pkg::MODE_QUERY, 24'h000000, 24'h7fffff, 24'h800000);
    push_item(dpi_pkg::MODE_UNUSED, 24'h123456, 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_LOAD, 24'h800000, 24'h7fffff, 24'h800000);
    push_item(dpi_pkg::MODE_LOAD, 24'h7fffff, 24'h800000, 24'h7fffff);
    push_item(dpi_pkg::MODE_QUERY, 24'h800000, 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_QUERY, 24'h7fffff, 24'hffffff, 24'hffffff);
    push_item(dpi_pkg::MODE_QUERY, 24'h000000, 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_QUERY, 24'h800001, 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_QUERY, 24'h7ffffe, 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_LOAD, 24'h000100, 24'h010000, 24'hff0000);
    push_item(dpi_pkg::MODE_LOAD, 24'h000100, 24'h020000, 24'hfe0000);
    push_item(dpi_pkg::MODE_QUERY, 24'h000100, 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_QUERY, 24'h000080, 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_QUERY, 24'h000180, 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_CLEAR, 24'hffffff, 24'hffffff, 24'hffffff);
    push_item(dpi_pkg::MODE_QUERY, 24'h000100, 24'h0, 24'h0);
    // Fill the table and overflow it.
    for (int i = 0; i < LEVELS + 2; i++)
      push_item(dpi_pkg::MODE_LOAD, 24'(i * 97 - 3000), 24'($urandom()), 24'($urandom()));
    push_item(dpi_pkg::MODE_QUERY, 24'(100), 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_QUERY, 24'h7fffff, 24'h0, 24'h0);
    push_item(dpi_pkg::MODE_CLEAR, 24'h0, 24'h0, 24'h0);

    // Random: profiles of random size, then queries into them, with some noise.
    n = 0;
    while (n < 1065) begin
      if (n > 500 && !pressure_done) begin
        // Hold off the sender until every expected answer has arrived.
        wait (pending_items.size() == 0);
        hold_sender = 1;
        wait (expected_answers.size() == 0 && !s_tvalid);
        hold_sender = 0;
        pressure_done = 1;
      end
      style = $urandom_range(0, 2);
      repeat ($urandom_range(1, 12)) begin
        push_item(dpi_pkg::MODE_LOAD, rand_depth(style), 24'($urandom()), 24'($urandom()));
        n++;
      end
      repeat ($urandom_range(2, 15)) begin
        md = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : dpi_pkg::MODE_QUERY;
        push_item(md, rand_depth(style), 24'($urandom()), 24'($urandom())); n++;
      end
      if ($urandom_range(0, 3) == 0) begin
        push_item(dpi_pkg::MODE_CLEAR, 24'($urandom()), 24'h0, 24'h0); n++;
      end
    end
    wait (pending_items.size() == 0 && !s_tvalid);
    wait (expected_answers.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d answers, %0d interpolated queries, loads, overflow and clears",
             answers_seen, queries_lerp);
    if (mismatch_count == 0 && expected_answers.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end
endmodule
